@@ hw/rtl/clsm_pkg.sv @@
`default_nettype none

package clsm_pkg;

    localparam int MAX_LINE_DEF = 4096;

    localparam logic [2:0] MODE_START  = 3'd0;
    localparam logic [2:0] MODE_NUMBER = 3'd1;
    localparam logic [2:0] MODE_IDENT  = 3'd2;
    localparam logic [2:0] MODE_STRING = 3'd3;
    localparam logic [2:0] MODE_BLOCK  = 3'd4;
    localparam logic [2:0] MODE_LINE   = 3'd5;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_NUMBER = 2'd0;
    localparam kind_t KIND_STRING = 2'd1;
    localparam kind_t KIND_BLOCK  = 2'd2;
    localparam kind_t KIND_LINE   = 2'd3;

    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_SQUOTE     = 8'h27;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || (c == CH_UNDERSCORE);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/code_lexer_span_marker_core.sv @@
`default_nettype none

// Streaming lexer that marks number, string, block comment and line comment spans in a
// source line. Each input item carries one character, or an end-of-line marker, and one
// item is taken every clock while the result side keeps up. An item yields at most one
// span, which goes through a two-entry output buffer, so a stalled result side stops
// input only once two spans are waiting. Columns saturate at MAX_LINE, and a block
// comment left open at a line end continues at column 0 of the next.
module code_lexer_span_marker_core
    import clsm_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF,
    localparam int SW = $clog2(MAX_LINE),
    localparam int CW = $clog2(MAX_LINE + 1)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_char_code,
    input  wire logic          s_line_end,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [SW-1:0]      m_span_start,
    output logic [CW-1:0]      m_span_length,
    output kind_t              m_span_kind
);

    localparam logic [CW-1:0] COL_MAX = CW'(MAX_LINE);
    localparam logic [CW-1:0] COL_TOP = CW'(MAX_LINE - 1);
    localparam logic [SW-1:0] TS_MAX  = SW'(MAX_LINE - 1);
    localparam int            DW      = SW + CW + 2;

    logic [2:0]    mode_reg, mode_next;
    logic          slash_reg, slash_next;
    logic          star_reg, star_next;
    logic [7:0]    quote_reg, quote_next;
    logic [7:0]    prev_reg, prev_next;
    logic [SW-1:0] token_start_reg, token_start_next;
    logic [CW-1:0] column_reg, column_next;

    logic          accept;
    logic [7:0]    c;
    logic [CW-1:0] nxt;
    logic [SW-1:0] pos_clamp;
    logic [2:0]    bt_mode;
    logic          bt_slash;
    logic          bt_quote;
    logic          span_req;
    logic [CW-1:0] span_end;
    kind_t         span_kind;
    logic          span_valid;
    logic [CW-1:0] span_length;
    logic [DW-1:0] span_data;
    logic [DW-1:0] out_data;

    assign accept    = s_valid && s_ready;
    assign c         = s_char_code;
    assign nxt       = (column_reg < COL_MAX) ? column_reg + CW'(1) : COL_MAX;
    assign pos_clamp = (column_reg < COL_TOP) ? column_reg[SW-1:0] : TS_MAX;

    always_comb begin
        bt_mode  = MODE_START;
        bt_slash = 1'b0;
        bt_quote = 1'b0;
        if (is_digit(c)) begin
            bt_mode = MODE_NUMBER;
        end else if (is_letter(c) || (c == CH_UNDERSCORE)) begin
            bt_mode = MODE_IDENT;
        end else if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
            bt_mode  = MODE_STRING;
            bt_quote = 1'b1;
        end else if (c == CH_SLASH) begin
            bt_slash = 1'b1;
        end
    end

    always_comb begin
        mode_next        = mode_reg;
        slash_next       = slash_reg;
        star_next        = star_reg;
        quote_next       = quote_reg;
        prev_next        = c;
        token_start_next = token_start_reg;
        column_next      = nxt;
        span_req         = 1'b0;
        span_end         = column_reg;
        span_kind        = KIND_NUMBER;

        if (s_line_end) begin
            case (mode_reg)
                MODE_NUMBER: begin
                    span_req  = 1'b1;
                    span_kind = KIND_NUMBER;
                end
                MODE_LINE: begin
                    span_req  = 1'b1;
                    span_kind = KIND_LINE;
                end
                MODE_BLOCK: begin
                    span_req  = 1'b1;
                    span_kind = KIND_BLOCK;
                end
                default: begin
                    span_req = 1'b0;
                end
            endcase
            if (mode_reg != MODE_BLOCK) begin
                mode_next = MODE_START;
            end
            token_start_next = '0;
            slash_next       = 1'b0;
            star_next        = 1'b0;
            quote_next       = '0;
            prev_next        = '0;
            column_next      = '0;
        end else begin
            case (mode_reg)
                MODE_START: begin
                    if (slash_reg && (c == CH_STAR)) begin
                        slash_next = 1'b0;
                        mode_next  = MODE_BLOCK;
                        star_next  = 1'b0;
                    end else if (slash_reg && (c == CH_SLASH)) begin
                        slash_next = 1'b0;
                        mode_next  = MODE_LINE;
                    end else begin
                        mode_next        = bt_mode;
                        slash_next       = bt_slash;
                        token_start_next = pos_clamp;
                        if (bt_quote) begin
                            quote_next = c;
                        end
                    end
                end
                MODE_NUMBER: begin
                    if (!is_digit(c)) begin
                        span_req         = 1'b1;
                        span_kind        = KIND_NUMBER;
                        mode_next        = bt_mode;
                        slash_next       = bt_slash;
                        token_start_next = pos_clamp;
                        if (bt_quote) begin
                            quote_next = c;
                        end
                    end
                end
                MODE_IDENT: begin
                    if (!is_ident_char(c)) begin
                        mode_next        = bt_mode;
                        slash_next       = bt_slash;
                        token_start_next = pos_clamp;
                        if (bt_quote) begin
                            quote_next = c;
                        end
                    end
                end
                MODE_STRING: begin
                    if ((c == quote_reg) && (prev_reg != CH_BACKSLASH)) begin
                        span_req  = 1'b1;
                        span_end  = nxt;
                        span_kind = KIND_STRING;
                        mode_next = MODE_START;
                    end
                end
                MODE_BLOCK: begin
                    if (star_reg && (c == CH_SLASH)) begin
                        span_req  = 1'b1;
                        span_end  = nxt;
                        span_kind = KIND_BLOCK;
                        mode_next = MODE_START;
                        star_next = 1'b0;
                    end else begin
                        star_next = (c == CH_STAR);
                    end
                end
                MODE_LINE: begin
                    mode_next = MODE_LINE;
                end
                default: begin
                    star_next        = 1'b0;
                    mode_next        = bt_mode;
                    slash_next       = bt_slash;
                    token_start_next = pos_clamp;
                    if (bt_quote) begin
                        quote_next = c;
                    end
                end
            endcase
        end
    end

    assign span_valid  = accept && span_req && (span_end > {1'b0, token_start_reg});
    assign span_length = span_end - {1'b0, token_start_reg};
    assign span_data   = {token_start_reg, span_length, span_kind};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_START;
            slash_reg       <= 1'b0;
            star_reg        <= 1'b0;
            quote_reg       <= '0;
            prev_reg        <= '0;
            token_start_reg <= '0;
            column_reg      <= '0;
        end else if (accept) begin
            mode_reg        <= mode_next;
            slash_reg       <= slash_next;
            star_reg        <= star_next;
            quote_reg       <= quote_next;
            prev_reg        <= prev_next;
            token_start_reg <= token_start_next;
            column_reg      <= column_next;
        end
    end

    clsm_skid #(
        .WIDTH(DW)
    ) u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (span_valid),
        .in_ready (s_ready),
        .in_data  (span_data),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_data (out_data)
    );

    assign m_span_start  = out_data[DW-1 -: SW];
    assign m_span_length = out_data[CW+1 -: CW];
    assign m_span_kind   = out_data[1:0];

endmodule

`default_nettype wire

@@ hw/rtl/clsm_skid.sv @@
`default_nettype none

module clsm_skid #(
    parameter int WIDTH = 27
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    logic             out_valid_reg;
    logic [WIDTH-1:0] out_data_reg;
    logic             skid_valid_reg;
    logic [WIDTH-1:0] skid_data_reg;
    logic             out_free;
    logic             push;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign push      = in_valid && !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            if (out_free) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= in_data;
            end else begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= in_data;
            end
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/clsm_checker.sv @@
`default_nettype none

module clsm_checker
    import clsm_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF,
    localparam int SW = $clog2(MAX_LINE),
    localparam int CW = $clog2(MAX_LINE + 1)
) (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_ready,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire logic [SW-1:0] m_span_start,
    input wire logic [CW-1:0] m_span_length,
    input wire kind_t         m_span_kind
);

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

    a_span_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_span_length != '0))
        else $error("Empty span emitted.");

    a_span_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((int'(m_span_start) + int'(m_span_length)) <= MAX_LINE))
        else $error("Span runs past the end of the line.");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("Input stalled with no result waiting.");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_span_start)
            && $stable(m_span_length) && $stable(m_span_kind)))
        else $error("Stalled result item changed.");

endmodule

bind code_lexer_span_marker_core clsm_checker #(.MAX_LINE(MAX_LINE)) u_clsm_checker (.*);

`default_nettype wire

@@ tb/clsm_span_checker.sv @@
`timescale 1ns / 1ps

module clsm_span_checker
    import clsm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_char_code,
    input  wire logic        s_line_end,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [11:0] m_span_start,
    input  wire logic [12:0] m_span_length,
    input  wire kind_t       m_span_kind,
    output int               fail_count,
    output int               outstanding,
    output int               spans_checked
);

    localparam int LINE_MAX = MAX_LINE_DEF;

    typedef struct packed {
        logic [11:0] start;
        logic [12:0] length;
        kind_t       kind;
    } span_t;

    span_t       span_q[$];
    logic [2:0]  mode;
    logic        slash_seen;
    logic        star_seen;
    logic [7:0]  open_quote;
    logic [7:0]  last_char;
    logic [11:0] tok_start;
    logic [12:0] column;

    function automatic logic digit_char(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic ident_head(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) || (c == CH_UNDERSCORE);
    endfunction

    function automatic void clear_scanner();
        mode       = MODE_START;
        slash_seen = 1'b0;
        star_seen  = 1'b0;
        open_quote = '0;
        last_char  = '0;
        tok_start  = '0;
        column     = '0;
    endfunction

    function automatic void close_span(input logic [12:0] end_col, input kind_t kind);
        span_t s;
        if (end_col > {1'b0, tok_start}) begin
            s.start  = tok_start;
            s.length = end_col - {1'b0, tok_start};
            s.kind   = kind;
            span_q.push_back(s);
        end
    endfunction

    function automatic void open_token(input logic [7:0] c, input logic [12:0] pos);
        tok_start = (pos < LINE_MAX - 1) ? pos[11:0] : 12'(LINE_MAX - 1);
        mode = MODE_START;
        if (digit_char(c)) begin
            mode = MODE_NUMBER;
        end else if (ident_head(c)) begin
            mode = MODE_IDENT;
        end else if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
            mode = MODE_STRING;
            open_quote = c;
        end else if (c == CH_SLASH) begin
            slash_seen = 1'b1;
        end
    endfunction

    function automatic void scan_item(input logic [7:0] c, input logic eol);
        logic [12:0] pos;
        logic [12:0] nxt;
        pos = column;
        nxt = (column < LINE_MAX) ? column + 13'd1 : 13'(LINE_MAX);
        if (eol) begin
            case (mode)
                MODE_NUMBER: close_span(column, KIND_NUMBER);
                MODE_LINE:   close_span(column, KIND_LINE);
                MODE_BLOCK:  close_span(column, KIND_BLOCK);
                default: ;
            endcase
            if (mode != MODE_BLOCK) mode = MODE_START;
            tok_start  = '0;
            slash_seen = 1'b0;
            star_seen  = 1'b0;
            open_quote = '0;
            last_char  = '0;
            column     = '0;
        end else begin
            case (mode)
                MODE_START: begin
                    if (slash_seen) begin
                        slash_seen = 1'b0;
                        if (c == CH_STAR) begin
                            mode = MODE_BLOCK;
                            star_seen = 1'b0;
                        end else if (c == CH_SLASH) begin
                            mode = MODE_LINE;
                        end else begin
                            open_token(c, pos);
                        end
                    end else begin
                        open_token(c, pos);
                    end
                end
                MODE_NUMBER: begin
                    if (!digit_char(c)) begin
                        close_span(pos, KIND_NUMBER);
                        open_token(c, pos);
                    end
                end
                MODE_IDENT: begin
                    if (!(ident_head(c) || digit_char(c))) open_token(c, pos);
                end
                MODE_STRING: begin
                    if ((c == open_quote) && (last_char != CH_BACKSLASH)) begin
                        close_span(nxt, KIND_STRING);
                        mode = MODE_START;
                    end
                end
                MODE_BLOCK: begin
                    if (star_seen && (c == CH_SLASH)) begin
                        close_span(nxt, KIND_BLOCK);
                        mode = MODE_START;
                        star_seen = 1'b0;
                    end else begin
                        star_seen = (c == CH_STAR);
                    end
                end
                MODE_LINE: ;
                default: begin
                    slash_seen = 1'b0;
                    star_seen  = 1'b0;
                    open_token(c, pos);
                end
            endcase
            last_char = c;
            column    = nxt;
        end
    endfunction

    always @(posedge aclk) begin
        span_t want;
        if (!aresetn) begin
            clear_scanner();
            span_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (span_q.size() == 0) begin
                    $error("span with no item waiting: start %0d, length %0d, kind %0d",
                           m_span_start, m_span_length, m_span_kind);
                    fail_count++;
                end else begin
                    want = span_q.pop_front();
                    spans_checked++;
                    if (m_span_start !== want.start) begin
                        $error("span_start: expected %0d, got %0d", want.start, m_span_start);
                        fail_count++;
                    end
                    if (m_span_length !== want.length) begin
                        $error("span_length: expected %0d, got %0d",
                               want.length, m_span_length);
                        fail_count++;
                    end
                    if (m_span_kind !== want.kind) begin
                        $error("span_kind: expected %0d, got %0d", want.kind, m_span_kind);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) scan_item(s_char_code, s_line_end);
        end
        outstanding <= span_q.size();
    end

endmodule

@@ tb/code_lexer_span_marker_core_tb.sv @@
`timescale 1ns / 1ps

module code_lexer_span_marker_core_tb;
    import clsm_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_code = 8'h00;
    logic        s_line_end = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [11:0] m_span_start;
    logic [12:0] m_span_length;
    kind_t       m_span_kind;

    int fail_count;
    int outstanding;
    int spans_checked;
    int n_items = 0;
    int n_chars = 0;
    int n_lines = 0;
    int cyc = 0;
    bit no_gaps = 1'b0;

    code_lexer_span_marker_core DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_code  (s_char_code),
        .s_line_end   (s_line_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_span_start (m_span_start),
        .m_span_length(m_span_length),
        .m_span_kind  (m_span_kind)
    );

    clsm_span_checker span_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_code  (s_char_code),
        .s_line_end   (s_line_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_span_start (m_span_start),
        .m_span_length(m_span_length),
        .m_span_kind  (m_span_kind),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .spans_checked(spans_checked)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if ((cyc >= 700) && (cyc < 1500)) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 37);
        end
    end

    task automatic send_item(input logic [7:0] c, input logic eol);
        if (!no_gaps) begin
            while ($urandom_range(99) < 37) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_char_code <= c;
        s_line_end  <= eol;
        do @(posedge aclk); while (!s_ready);
        n_items++;
        if (eol) n_lines++;
        else n_chars++;
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) send_item(t[i], 1'b0);
    endtask

    task automatic send_eol();
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    function automatic logic [7:0] plain_char();
        string pool = "abzAQZ0159_ .,;()+-=";
        return pool[$urandom_range(pool.len() - 1)];
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(1)) return 8'("a" + $urandom_range(25));
        return 8'("A" + $urandom_range(25));
    endfunction

    task automatic random_line();
        logic [7:0] txt[$];
        logic [7:0] q;
        repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    repeat ($urandom_range(1, 6)) txt.push_back(8'("0" + $urandom_range(9)));
                end
                2: begin
                    txt.push_back(($urandom_range(3) == 0) ? CH_UNDERSCORE : rand_letter());
                    repeat ($urandom_range(0, 5)) begin
                        case ($urandom_range(2))
                            0: txt.push_back(rand_letter());
                            1: txt.push_back(8'("0" + $urandom_range(9)));
                            default: txt.push_back(CH_UNDERSCORE);
                        endcase
                    end
                end
                3: begin
                    q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
                    txt.push_back(q);
                    repeat ($urandom_range(0, 6)) begin
                        case ($urandom_range(0, 4))
                            0: txt.push_back(CH_BACKSLASH);
                            1: begin
                                txt.push_back(CH_BACKSLASH);
                                txt.push_back(q);
                            end
                            2: txt.push_back((q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE);
                            default: txt.push_back(plain_char());
                        endcase
                    end
                    if ($urandom_range(9) != 0) txt.push_back(q);
                end
                4: begin
                    txt.push_back(CH_SLASH);
                    txt.push_back(CH_STAR);
                    repeat ($urandom_range(0, 6)) begin
                        case ($urandom_range(0, 3))
                            0: txt.push_back(CH_STAR);
                            1: txt.push_back(CH_SLASH);
                            default: txt.push_back(plain_char());
                        endcase
                    end
                    if ($urandom_range(4) != 0) begin
                        txt.push_back(CH_STAR);
                        txt.push_back(CH_SLASH);
                    end
                end
                5: txt.push_back(plain_char());
                6: txt.push_back($urandom_range(1) ? CH_SLASH : CH_STAR);
                7: txt.push_back(8'($urandom_range(255)));
                8: begin
                    txt.push_back(CH_SLASH);
                    txt.push_back(CH_SLASH);
                    repeat ($urandom_range(0, 5)) txt.push_back(8'($urandom_range(255)));
                end
                default: repeat ($urandom_range(1, 3)) txt.push_back(" ");
            endcase
            if ($urandom_range(9) < 6) txt.push_back(" ");
        end
        foreach (txt[i]) send_item(txt[i], 1'b0);
        send_eol();
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 20)) begin
            send_item(8'($urandom_range(255)), ($urandom_range(99) < 8));
        end
    endtask

    initial begin
        int mark;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text("42//");
        send_eol();
        send_text("'\\'\"'/*/*");
        send_eol();
        send_eol();
        send_text("/*/");
        send_eol();
        send_text("_9/5'");
        send_eol();
        wait_drained();

        for (int i = 0; n_items < 960; i++) begin
            no_gaps = (i >= 20) && (i < 45);
            if ($urandom_range(99) < 15) noise_burst();
            else random_line();
        end
        no_gaps = 1'b0;
        wait_drained();

        mark = n_items;
        while (n_items - mark < 960) begin
            if ($urandom_range(99) < 15) noise_burst();
            else random_line();
        end
        wait_drained();
        repeat (20) @(posedge aclk);

        $display("Scanned %0d characters over %0d lines with random stalls on both sides.",
                 n_chars, n_lines);
        $display("Compared %0d spans of numbers, strings and comments.", spans_checked);
        if (fail_count == 0) begin
            $display("code_lexer_span_marker_core: match");
        end else begin
            $display("code_lexer_span_marker_core: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("code_lexer_span_marker_core: mismatch");
        $finish;
    end

endmodule
